/* design/bfst_pkg.sv */
`timescale 1ns / 1ps

package bfst_pkg;

   localparam int WORD_W = 32;
   localparam int CFG_W  = 17;
   localparam int BYTE_W = 8;

   localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_step;
      logic rd_issue;
      logic apply;
   } bfst_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic item_last;
   } bfst_status_type;

endpackage

/* design/bfst_ram.sv */
`timescale 1ns / 1ps

module bfst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bfst_ctrl.sv */
`timescale 1ns / 1ps

module bfst_ctrl
   import bfst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  bfst_status_type status,
   output bfst_cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_APPLY = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            // a key's result waits until the output register is free
            if (!status.item_last || out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.apply && status.item_last) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/bfst_dp.sv */
`timescale 1ns / 1ps

module bfst_dp
   import bfst_pkg::*;
#(
   parameter int MAX_BITS = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  bfst_cmd_type      cmd,
   output bfst_status_type   status,
   input  logic              req_mode,
   input  logic [WORD_W-1:0] req_hash_word,
   input  logic              req_last_hash,
   output logic              rsp_maybe_present,
   input  logic              csr_valid,
   input  logic [CFG_W-1:0]  csr_filter_bits
);

   localparam int DEPTH  = (MAX_BITS + 7) / 8;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = $clog2(MAX_BITS);
   localparam int DIV_W  = $clog2(MAX_BITS + 1);
   localparam int CNT_W  = $clog2(WORD_W);

   logic [CFG_W-1:0]  filter_bits_ff;
   logic [DIV_W-1:0]  size_in;
   logic [DIV_W-1:0]  div_ff;
   logic [WORD_W-1:0] word_ff;
   logic [POS_W-1:0]  rem_ff;
   logic [POS_W-1:0]  rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic              mode_ff;
   logic              last_ff;
   logic              hits_ff;
   logic              hits_in;
   logic              maybe_ff;

   logic [POS_W:0]    trial;
   logic [POS_W:0]    diff;
   logic [ADDR_W+2:0] pos_ext;
   logic [ADDR_W-1:0] byte_addr;
   logic [BYTE_W-1:0] sel_mask;
   logic [BYTE_W-1:0] rd_data;
   logic              bit_hit;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;

   // zero acts as one, anything above the store acts as the store size
   always_comb begin
      if (filter_bits_ff == '0) begin
         size_in = DIV_W'(1);
      end else if (32'(filter_bits_ff) > 32'(MAX_BITS)) begin
         size_in = DIV_W'(MAX_BITS);
      end else begin
         size_in = DIV_W'(filter_bits_ff);
      end
   end

   // one restoring step per cycle, msb first
   assign trial = {rem_ff, word_ff[WORD_W-1]};
   assign diff  = trial - (POS_W+1)'(div_ff);

   always_comb begin
      if (trial >= (POS_W+1)'(div_ff)) begin
         rem_in = diff[POS_W-1:0];
      end else begin
         rem_in = trial[POS_W-1:0];
      end
   end

   assign pos_ext   = (ADDR_W+3)'(rem_ff);
   assign byte_addr = pos_ext[ADDR_W+2:3];
   assign sel_mask  = BYTE_W'(1) << rem_ff[2:0];
   assign bit_hit   = |(rd_data & sel_mask);

   assign hits_in = mode_ff ? (hits_ff && bit_hit) : hits_ff;

   assign wr_en   = cmd.clr_step || (cmd.apply && !mode_ff);
   assign wr_addr = cmd.clr_step ? clr_ff : byte_addr;
   assign wr_data = cmd.clr_step ? '0 : (rd_data | sel_mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= CFG_RESET;
         clr_ff         <= '0;
         cnt_ff         <= '0;
         hits_ff        <= 1'b1;
      end else begin
         if (csr_valid) begin
            filter_bits_ff <= csr_filter_bits;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.apply) begin
            hits_ff <= last_ff ? 1'b1 : hits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         last_ff <= req_last_hash;
         word_ff <= req_hash_word;
         div_ff  <= size_in;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         word_ff <= {word_ff[WORD_W-2:0], 1'b0};
         rem_ff  <= rem_in;
      end
      if (cmd.apply && last_ff) begin
         maybe_ff <= !mode_ff || hits_in;
      end
   end

   bfst_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (byte_addr),
      .rd_data (rd_data)
   );

   assign status.clr_last  = (clr_ff == ADDR_W'(DEPTH - 1));
   assign status.div_last  = (cnt_ff == CNT_W'(WORD_W - 1));
   assign status.item_last = last_ff;

   assign rsp_maybe_present = maybe_ff;

endmodule

/* design/bloom_filter_set_test.sv */
`timescale 1ns / 1ps

// bloom filter bit store with add and check of precomputed 32-bit hash words
// req channel: one item per hash word (mode, hash word, last flag), taken on
//   req_valid high and req_stall low; req_stall stays high while an item works
// rsp channel: one item per key, on the item with the last flag set; it sits
//   in an output register and holds while rsp_stall is high
// csr channel: writes filter_bits, the modulus; csr_ready is always high;
//   the user makes a write only while the block is idle; the block does not
//   enforce it; each item goes through a load, the bit-serial remainder (one
//   quotient bit per cycle), a store read and a write back with the result;
//   the next item is taken only after that
// the result is registered in that write-back step; a key whose
//   result finds the output register still full waits there until it drains
// reset: synchronous; the store is then swept to zero one byte per cycle,
//   all (MAX_BITS + 7) / 8 bytes (8192 by default), with req_stall high
// filter_bits of zero acts as one, above MAX_BITS acts as MAX_BITS

module bloom_filter_set_test
   import bfst_pkg::*;
#(
   parameter int MAX_BITS = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [WORD_W-1:0] req_hash_word,
   input  logic              req_last_hash,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_maybe_present,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_filter_bits
);

   bfst_cmd_type    cmd;
   bfst_status_type status;

   assign csr_ready = 1'b1;

   bfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfst_dp #(
      .MAX_BITS (MAX_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_hash_word     (req_hash_word),
      .req_last_hash     (req_last_hash),
      .rsp_maybe_present (rsp_maybe_present),
      .csr_valid         (csr_valid && csr_ready),
      .csr_filter_bits   (csr_filter_bits)
   );

   // an accepted item keeps the input side closed while it works
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted item");

   // a result appears only at the end of an item's work
   a_rsp_from_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while the block was idle");

   a_no_rsp_on_load : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result raised in the cycle after an accept");

endmodule
